### design/bgi_pkg.sv
`timescale 1ns / 1ps

package bgi_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_SCALE_X    = 3'd2,
        CFG_SCALE_Y    = 3'd3,
        CFG_CELLS_USED = 3'd4
    } cfg_index_t;

    // Item function codes.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // Fixed port widths.
    localparam int COORD_W  = 32;
    localparam int SCALE_W  = 24;
    localparam int USED_W   = 6;
    localparam int INDEX_W  = 12;
    localparam int ENTRY_W  = 24;
    localparam int VALUE_W  = 24;
    localparam int CFG_IDX_W = 3;

    // Fraction bits of the scaled coordinate product.
    localparam int COORD_FRAC = 32;

endpackage

### design/bilinear_grid_interpolator.sv
`timescale 1ns / 1ps

// Bilinear interpolator over a square table of complex samples, POINTS_PER_SIDE on
// a side, stored row by row (entry_index = column + row * POINTS_PER_SIDE). An item is
// taken at every rising edge where start is high; busy is always low, so a new item can
// follow in every cycle and the block sustains one item per cycle. A write item
// (func = 0) stores one sample and gives no result; an index beyond the table is ignored.
// A lookup item (func = 1) gives exactly one result, marked by done for one cycle; the
// receiver cannot stall, and results leave in the order the items came. Points before
// the origin or past the last used cell give zeros with in_range low. The pipeline
// stages are origin subtract, scale multiply, table read, row blend along x, column
// blend along y, and the final rounding. The table is held twice, once for the upper
// and once for the lower corner row of a cell, and each copy is read at two addresses
// per cycle, so all four corners come back in the same cycle.
// Writes travel down the same stages as lookups and reach the table at the very edge at
// which a lookup would read it, so every lookup sees exactly the writes taken before it.
// Entries never written read back as arbitrary data. Configuration writes are always
// accepted (cfg_ready is high) and must only be made while no lookup is in flight.
module bilinear_grid_interpolator #(
    parameter int POINTS_PER_SIDE = 64,
    parameter int SAMPLE_BITS     = 24,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Item channel.
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic signed [bgi_pkg::COORD_W-1:0] coord_x,
    input  logic signed [bgi_pkg::COORD_W-1:0] coord_y,
    input  logic        [bgi_pkg::INDEX_W-1:0] entry_index,
    input  logic signed [bgi_pkg::ENTRY_W-1:0] entry_re,
    input  logic signed [bgi_pkg::ENTRY_W-1:0] entry_im,
    // Result channel.
    output logic                               done,
    output logic signed [bgi_pkg::VALUE_W-1:0] value_re,
    output logic signed [bgi_pkg::VALUE_W-1:0] value_im,
    output logic                               in_range,
    // Configuration channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic      [bgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [bgi_pkg::COORD_W-1:0] cfg_data
);

    localparam int P     = POINTS_PER_SIDE;
    localparam int S     = SAMPLE_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int DEPTH = P * P;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(P);
    // Guard shift keeps the row values narrow enough for very wide configurations.
    localparam int G     = ((S + 2 * F) > 62) ? (S + 2 * F - 62) : 0;
    localparam int RW    = S + F + 1;       // row blend width before the guard shift
    localparam int RGW   = RW - G;          // row value width after the guard shift
    localparam int ACW   = RGW + F + 1;     // column blend width
    localparam int SH2   = 2 * F - G;       // final rounding shift
    localparam int TW    = bgi_pkg::COORD_W + 1;
    localparam int PW    = TW + bgi_pkg::SCALE_W + 1;
    localparam int CELLW = PW - 1 - bgi_pkg::COORD_FRAC;
    localparam int LIM   = P - 1;

    localparam logic [RW:0]  RND_ROW = ((RW + 1)'(1) << G) >> 1;
    localparam logic [ACW:0] RND_ACC = ((ACW + 1)'(1) << SH2) >> 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [bgi_pkg::COORD_W-1:0] origin_x_reg, origin_y_reg;
    logic        [bgi_pkg::SCALE_W-1:0] scale_x_reg, scale_y_reg;
    logic        [bgi_pkg::USED_W-1:0]  cells_used_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            scale_x_reg    <= bgi_pkg::SCALE_W'(65536);
            scale_y_reg    <= bgi_pkg::SCALE_W'(65536);
            cells_used_reg <= bgi_pkg::USED_W'(63);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bgi_pkg::cfg_index_t'(cfg_index))
                bgi_pkg::CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                bgi_pkg::CFG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                bgi_pkg::CFG_SCALE_X:    scale_x_reg    <= cfg_data[bgi_pkg::SCALE_W-1:0];
                bgi_pkg::CFG_SCALE_Y:    scale_y_reg    <= cfg_data[bgi_pkg::SCALE_W-1:0];
                bgi_pkg::CFG_CELLS_USED: cells_used_reg <= cfg_data[bgi_pkg::USED_W-1:0];
                default: ;
            endcase
        end
    end

    // Cells in use, limited to what the table can hold.
    logic [CELLW-1:0] used_cells;
    assign used_cells = (32'(cells_used_reg) > LIM) ? CELLW'(LIM) : CELLW'(cells_used_reg);

    // ------------------------------------------------------------------
    // Stage 1: origin subtract; write items carry their entry along.
    // ------------------------------------------------------------------
    logic                 s1_valid_reg, s1_lookup_reg;
    logic signed [TW-1:0] s1_tx_reg, s1_ty_reg;
    logic [AW-1:0]        s1_waddr_reg;
    logic                 s1_wok_reg;
    logic [2*S-1:0]       s1_wdata_reg;

    logic accept;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lookup_reg <= (func == bgi_pkg::FUNC_LOOKUP);
            s1_tx_reg     <= TW'(coord_x) - TW'(origin_x_reg);
            s1_ty_reg     <= TW'(coord_y) - TW'(origin_y_reg);
            s1_waddr_reg  <= AW'(entry_index);
            s1_wok_reg    <= (32'(entry_index) < DEPTH);
            s1_wdata_reg  <= {S'(entry_im), S'(entry_re)};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale multiply.
    // ------------------------------------------------------------------
    logic                 s2_valid_reg, s2_lookup_reg, s2_wok_reg;
    logic signed [PW-1:0] s2_px_reg, s2_py_reg;
    logic [AW-1:0]        s2_waddr_reg;
    logic [2*S-1:0]       s2_wdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_lookup_reg <= s1_lookup_reg;
            s2_wok_reg    <= s1_wok_reg;
            s2_waddr_reg  <= s1_waddr_reg;
            s2_wdata_reg  <= s1_wdata_reg;
            s2_px_reg     <= PW'(s1_tx_reg * $signed({1'b0, scale_x_reg}));
            s2_py_reg     <= PW'(s1_ty_reg * $signed({1'b0, scale_y_reg}));
        end
    end

    // Cell index, fraction and range check from the scaled offsets.
    logic [CELLW-1:0] cell_x, cell_y;
    logic [F-1:0]     frac_x, frac_y;
    logic             point_in;
    logic [AW-1:0]    base_addr;

    assign cell_x   = s2_px_reg[bgi_pkg::COORD_FRAC +: CELLW];
    assign cell_y   = s2_py_reg[bgi_pkg::COORD_FRAC +: CELLW];
    assign frac_x   = s2_px_reg[bgi_pkg::COORD_FRAC - F +: F];
    assign frac_y   = s2_py_reg[bgi_pkg::COORD_FRAC - F +: F];
    assign point_in = !s2_px_reg[PW-1] && !s2_py_reg[PW-1]
                      && (cell_x < used_cells) && (cell_y < used_cells);
    assign base_addr = AW'(32'(cell_x[CW-1:0]) + 32'(cell_y[CW-1:0]) * P);

    // ------------------------------------------------------------------
    // Table: two copies, each written together and read at two addresses.
    // ------------------------------------------------------------------
    logic [2*S-1:0] mem_top [DEPTH];
    logic [2*S-1:0] mem_bot [DEPTH];
    logic [2*S-1:0] rd_00_reg, rd_01_reg, rd_10_reg, rd_11_reg;
    logic           mem_we, mem_re;

    assign mem_we = s2_valid_reg && !s2_lookup_reg && s2_wok_reg;
    assign mem_re = s2_valid_reg && s2_lookup_reg && point_in;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_top[s2_waddr_reg] <= s2_wdata_reg;
        end
        if (mem_re)
        begin
            rd_00_reg <= mem_top[base_addr];
            rd_01_reg <= mem_top[base_addr + AW'(1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_bot[s2_waddr_reg] <= s2_wdata_reg;
        end
        if (mem_re)
        begin
            rd_10_reg <= mem_bot[base_addr + AW'(P)];
            rd_11_reg <= mem_bot[base_addr + AW'(P + 1)];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: lookup control beside the read data.
    // ------------------------------------------------------------------
    logic         s3_valid_reg, s3_in_reg;
    logic [F-1:0] s3_fx_reg, s3_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg && s2_lookup_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_in_reg <= point_in;
            s3_fx_reg <= frac_x;
            s3_fy_reg <= frac_y;
        end
    end

    // Row blends along x, then the guard rounding.
    logic signed [F+1:0] wx0, wx1, wy0, wy1;
    logic signed [RW-1:0] row0_re, row0_im, row1_re, row1_im;
    logic signed [RW:0]   row0_re_r, row0_im_r, row1_re_r, row1_im_r;

    assign wx1 = $signed({2'b00, s3_fx_reg});
    assign wx0 = $signed((F + 2)'(1) << F) - wx1;

    assign row0_re = RW'($signed(rd_00_reg[S-1:0]) * wx0 + $signed(rd_01_reg[S-1:0]) * wx1);
    assign row0_im = RW'($signed(rd_00_reg[2*S-1:S]) * wx0
                         + $signed(rd_01_reg[2*S-1:S]) * wx1);
    assign row1_re = RW'($signed(rd_10_reg[S-1:0]) * wx0 + $signed(rd_11_reg[S-1:0]) * wx1);
    assign row1_im = RW'($signed(rd_10_reg[2*S-1:S]) * wx0
                         + $signed(rd_11_reg[2*S-1:S]) * wx1);

    assign row0_re_r = (RW + 1)'(row0_re) + $signed(RND_ROW);
    assign row0_im_r = (RW + 1)'(row0_im) + $signed(RND_ROW);
    assign row1_re_r = (RW + 1)'(row1_re) + $signed(RND_ROW);
    assign row1_im_r = (RW + 1)'(row1_im) + $signed(RND_ROW);

    // ------------------------------------------------------------------
    // Stage 4: row values.
    // ------------------------------------------------------------------
    logic                  s4_valid_reg, s4_in_reg;
    logic [F-1:0]          s4_fy_reg;
    logic signed [RGW-1:0] s4_r0_re_reg, s4_r0_im_reg, s4_r1_re_reg, s4_r1_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            s4_in_reg    <= s3_in_reg;
            s4_fy_reg    <= s3_fy_reg;
            s4_r0_re_reg <= row0_re_r[G +: RGW];
            s4_r0_im_reg <= row0_im_r[G +: RGW];
            s4_r1_re_reg <= row1_re_r[G +: RGW];
            s4_r1_im_reg <= row1_im_r[G +: RGW];
        end
    end

    // Column blend along y.
    assign wy1 = $signed({2'b00, s4_fy_reg});
    assign wy0 = $signed((F + 2)'(1) << F) - wy1;

    // ------------------------------------------------------------------
    // Stage 5: blended value before the final rounding.
    // ------------------------------------------------------------------
    logic                  s5_valid_reg, s5_in_reg;
    logic signed [ACW-1:0] s5_acc_re_reg, s5_acc_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
        begin
            s5_in_reg     <= s4_in_reg;
            s5_acc_re_reg <= ACW'(s4_r0_re_reg * wy0 + s4_r1_re_reg * wy1);
            s5_acc_im_reg <= ACW'(s4_r0_im_reg * wy0 + s4_r1_im_reg * wy1);
        end
    end

    // Round half up to the sample format.
    logic signed [ACW:0] acc_re_r, acc_im_r;
    logic signed [S-1:0] res_re, res_im;

    assign acc_re_r = (ACW + 1)'(s5_acc_re_reg) + $signed(RND_ACC);
    assign acc_im_r = (ACW + 1)'(s5_acc_im_reg) + $signed(RND_ACC);
    assign res_re   = acc_re_r[SH2 +: S];
    assign res_im   = acc_im_r[SH2 +: S];

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic                               done_reg, in_range_reg;
    logic signed [bgi_pkg::VALUE_W-1:0] value_re_reg, value_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_valid_reg)
        begin
            in_range_reg <= s5_in_reg;
            value_re_reg <= s5_in_reg ? bgi_pkg::VALUE_W'(res_re) : '0;
            value_im_reg <= s5_in_reg ? bgi_pkg::VALUE_W'(res_im) : '0;
        end
    end

    assign done     = done_reg;
    assign in_range = in_range_reg;
    assign value_re = value_re_reg;
    assign value_im = value_im_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_lookup_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == bgi_pkg::FUNC_LOOKUP) |-> ##6 done)
        else $error("lookup item did not give a result after six cycles");

    a_write_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == bgi_pkg::FUNC_WRITE) |-> ##6 !done)
        else $error("write item gave a result");

    a_outside_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (value_re == '0 && value_im == '0))
        else $error("out of range result carries a nonzero value");

    a_no_read_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table read and write in the same cycle");

endmodule
